### src/assert_macros.svh
// Assertion helpers for the egcd block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EGCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EGCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EGCD_ASSERT(lbl, clk, rstn, prop, msg)
`define EGCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/egcd_pkg.sv
package egcd_pkg;

    localparam int WIDTH_DEF = 64;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic reduce;
    } t_cmd;

    typedef struct packed {
        logic r1_zero;
    } t_sts;

endpackage

### src/egcd_datapath.sv
module egcd_datapath #(
    parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
    input  logic              i_clk,
    input  egcd_pkg::t_cmd    i_cmd,
    input  logic [WIDTH-1:0]  i_value,
    input  logic [WIDTH-1:0]  i_modulus,
    output egcd_pkg::t_sts    o_sts,
    output logic [WIDTH-1:0]  o_inverse,
    output logic [WIDTH-1:0]  o_divisor
);

    logic [WIDTH-1:0] r_r, r_r1, r_u, r_u1, r_m, r_pr, r_dq, r_acc, r_inv, r_gcd;
    logic             r_neg;

    logic [WIDTH:0]   w_t;
    logic [WIDTH-1:0] w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] n_pr, n_acc, w_red0, w_inv;

    always_comb begin
        w_t    = {r_pr, r_dq[WIDTH-1]};
        w_diff = w_t[WIDTH-1:0] - r_r1;
        w_ge   = w_t >= {1'b0, r_r1};
        n_pr   = w_ge ? w_diff : w_t[WIDTH-1:0];
        n_acc  = {r_acc[WIDTH-2:0], 1'b0} + (w_ge ? r_u1 : '0);
        w_red0 = (r_u >= r_m) ? r_u - r_m : r_u;
        if (r_m == '0) begin
            w_inv = WIDTH'(1);
        end else if (r_neg && w_red0 != '0) begin
            w_inv = r_m - w_red0;
        end else begin
            w_inv = w_red0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r   <= i_value;
            r_r1  <= i_modulus;
            r_m   <= i_modulus;
            r_u   <= WIDTH'(1);
            r_u1  <= '0;
            r_neg <= 1'b0;
        end else if (i_cmd.div_init) begin
            r_pr  <= '0;
            r_dq  <= r_r;
            r_acc <= '0;
        end else if (i_cmd.div_step) begin
            r_pr  <= n_pr;
            r_dq  <= {r_dq[WIDTH-2:0], w_ge};
            r_acc <= n_acc;
        end else if (i_cmd.update) begin
            r_r   <= r_r1;
            r_r1  <= r_pr;
            r_u   <= r_u1;
            r_u1  <= r_acc + r_u;
            r_neg <= ~r_neg;
        end else if (i_cmd.reduce) begin
            r_inv <= w_inv;
            r_gcd <= r_r;
        end
    end

    assign o_sts.r1_zero = (r_r1 == '0);
    assign o_inverse     = r_inv;
    assign o_divisor     = r_gcd;

endmodule

### src/egcd_ctrl.sv
`include "assert_macros.svh"

module egcd_ctrl #(
    parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  egcd_pkg::t_sts  i_sts,
    output egcd_pkg::t_cmd  o_cmd
);

    localparam int CW = $clog2(WIDTH);

    egcd_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_div_done;

    assign w_div_done = (r_cnt == CW'(WIDTH - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            egcd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = egcd_pkg::S_CHECK;
                end
            end
            egcd_pkg::S_CHECK: begin
                if (i_sts.r1_zero) begin
                    o_cmd.reduce = 1'b1;
                    n_state      = egcd_pkg::S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = egcd_pkg::S_DIV;
                end
            end
            egcd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (w_div_done) begin
                    n_state = egcd_pkg::S_UPDATE;
                end
            end
            egcd_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_DONE: begin
                if (i_out_ready) begin
                    n_state = egcd_pkg::S_IDLE;
                end
            end
            default: n_state = egcd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egcd_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == egcd_pkg::S_IDLE);
    assign o_out_valid = (r_state == egcd_pkg::S_DONE);

    `EGCD_ASSERT(a_accept_to_check, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == egcd_pkg::S_CHECK), "accept did not start iteration")
    `EGCD_ASSERT(a_div_to_update, i_clk, i_rst_n, (r_state == egcd_pkg::S_DIV && w_div_done) |=> (r_state == egcd_pkg::S_UPDATE), "division did not end in update")
    `EGCD_ASSERT(a_done_from_check, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == egcd_pkg::S_CHECK), "result without final check")
endmodule

### src/extended_gcd_modular_inverse.sv
// Extended Euclid: returns gcd(value, modulus) and the coefficient of value
// reduced into 0..modulus-1 (the modular inverse when the gcd is 1). One
// request at a time. Each Euclid iteration runs a check state, a bit-serial
// restoring divider over all WIDTH quotient bits, and an update state; the
// number of iterations is data dependent, at most about 1.44 * WIDTH. A zero
// modulus returns gcd = value and coefficient 1.
module extended_gcd_modular_inverse #(
    parameter int WIDTH = egcd_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_value_in,
    input  logic [WIDTH-1:0] i_modulus_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_inverse_out,
    output logic [WIDTH-1:0] o_divisor_out
);

    egcd_pkg::t_cmd w_cmd;
    egcd_pkg::t_sts w_sts;

    egcd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    egcd_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_value   (i_value_in),
        .i_modulus (i_modulus_in),
        .o_sts     (w_sts),
        .o_inverse (o_inverse_out),
        .o_divisor (o_divisor_out)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int W = egcd_pkg::WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RX_HOLD_CYCLES = 600;

    typedef logic [W-1:0] t_word;

    typedef struct {
        t_word value;
        t_word modulus;
        bit    drain_first;
    } t_request;

    typedef struct {
        t_word inverse;
        t_word divisor;
    } t_result;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_word i_value_in = '0;
    t_word i_modulus_in = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_word o_inverse_out;
    t_word o_divisor_out;

    t_request pending_requests[$];
    t_result  expected_results[$];
    int n_sent = 0;
    int n_recv = 0;
    int n_fail = 0;
    int rx_hold = 0;
    int idle_cnt = 0;

    extended_gcd_modular_inverse #(.WIDTH(W)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_value_in(i_value_in), .i_modulus_in(i_modulus_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_inverse_out(o_inverse_out), .o_divisor_out(o_divisor_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result egcd_predict(t_word a, t_word m);
        t_result res;
        t_word r, r1, u, u1, q, nr, nu, red;
        bit neg;
        r = a; r1 = m; u = 1; u1 = 0; neg = 0;
        while (r1 != 0) begin
            q = r / r1;
            nr = r - q * r1;
            nu = u + q * u1;
            r = r1; r1 = nr;
            u = u1; u1 = nu;
            neg = !neg;
        end
        res.divisor = r;
        if (m == 0) begin
            res.inverse = u;
        end else begin
            red = u % m;
            if (neg && red != 0) red = m - red;
            res.inverse = red;
        end
        return res;
    endfunction

    function automatic t_word rand_word();
        t_word w;
        int bits;
        w = {$urandom, $urandom};
        bits = $urandom_range(1, W);
        if ($urandom_range(0, 2) != 0) w = w >> (W - bits);
        return w;
    endfunction

    function automatic bit idle_now(int cnt);
        if (cnt >= 60 && cnt < 95) return 0;
        return $urandom_range(0, 99) < 17;
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit accepted;
        bit offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            accepted = i_in_valid && o_in_ready;
            if (accepted) begin
                expected_results.push_back(egcd_predict(i_value_in, i_modulus_in));
                void'(pending_requests.pop_front());
                n_sent++;
            end
            if (!i_in_valid || accepted) begin
                offer = pending_requests.size() != 0 && !idle_now(n_sent);
                if (offer && pending_requests[0].drain_first
                        && (expected_results.size() != 0 || accepted))
                    offer = 0;
                if (offer) begin
                    i_value_in <= pending_requests[0].value;
                    i_modulus_in <= pending_requests[0].modulus;
                    pending_requests[0].drain_first = 0;
                end
                i_in_valid <= offer;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_recv++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result inverse=%h divisor=%h",
                           o_inverse_out, o_divisor_out);
                    n_fail++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_inverse_out !== exp_res.inverse) begin
                        $error("inverse_out expected %h actual %h",
                               exp_res.inverse, o_inverse_out);
                        n_fail++;
                    end
                    if (o_divisor_out !== exp_res.divisor) begin
                        $error("divisor_out expected %h actual %h",
                               exp_res.divisor, o_divisor_out);
                        n_fail++;
                    end
                end
                if (n_recv == 20) rx_hold = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_now(n_recv);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_request(t_word v, t_word m, bit drain = 0);
        t_request req;
        req.value = v;
        req.modulus = m;
        req.drain_first = drain;
        pending_requests.push_back(req);
    endtask

    initial begin
        t_word g;
        int k;
        add_request(0, 0);
        add_request(5, 0);
        add_request({W{1'b1}}, 0);
        add_request(0, 7);
        add_request(0, {W{1'b1}});
        add_request(3, 1);
        add_request(1, 1);
        add_request({W{1'b1}}, 1);
        add_request(3, 7);
        add_request(4, 8);
        add_request(17, 3120);
        add_request(240, 46);
        add_request(1, {W{1'b1}});
        add_request({W{1'b1}}, {W{1'b1}});
        add_request({W{1'b1}}, {W{1'b1}} - 1);
        add_request({W{1'b1}} - 1, {W{1'b1}});
        add_request(64'd7540113804746346429, 64'd12200160415121876738);
        add_request(64'd12200160415121876738, 64'd7540113804746346429);
        add_request(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        add_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        for (k = 0; k < 120; k++) begin
            case ($urandom_range(0, 3))
                0: add_request({$urandom, $urandom}, {$urandom, $urandom}, k == 40 || k == 100);
                1: begin
                    g = $urandom_range(2, 1000);
                    add_request(rand_word() * g, rand_word() * g, k == 40 || k == 100);
                end
                2: add_request(rand_word(), rand_word(), k == 40 || k == 100);
                default: add_request($urandom_range(0, 3) == 0 ? t_word'(0) : rand_word(),
                                     $urandom_range(0, 3) == 0 ? t_word'(0) : rand_word(),
                                     k == 40 || k == 100);
            endcase
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
